[rtl/core/ewt_pkg.sv]
// Shared types, codes and constants for the encoder position wrap tracker.
`default_nettype none

package ewt_pkg;

    // Fixed field widths
    localparam int unsigned POS_W   = 16;
    localparam int unsigned SENS_W  = 8;
    localparam int unsigned OP_W    = 2;
    localparam int unsigned DIR_W   = 2;
    localparam int unsigned CFG_W   = 16;
    localparam int unsigned CFGI_W  = 2;
    localparam int unsigned SPAN_W  = POS_W + 1;

    typedef logic [POS_W-1:0]  pos_t;
    typedef logic [SPAN_W-1:0] span_t;
    typedef logic [OP_W-1:0]   op_t;
    typedef logic [CFGI_W-1:0] cfg_index_t;

    // Operation codes
    localparam op_t OP_SAMPLE = 2'd0;
    localparam op_t OP_RESET  = 2'd1;
    localparam op_t OP_SET    = 2'd2;

    // Register indexes
    localparam cfg_index_t REG_MIN     = 2'd0;
    localparam cfg_index_t REG_MAX     = 2'd1;
    localparam cfg_index_t REG_SENS    = 2'd2;
    localparam cfg_index_t REG_INITIAL = 2'd3;

    // Register reset values
    localparam pos_t              MIN_RESET     = 16'd0;
    localparam pos_t              MAX_RESET     = 16'd1000;
    localparam logic [SENS_W-1:0] SENS_RESET    = 8'd5;
    localparam pos_t              INITIAL_RESET = 16'd0;

    // Direction codes (two's complement)
    localparam logic signed [DIR_W-1:0] DIR_ZERO = 2'sb00;
    localparam logic signed [DIR_W-1:0] DIR_UP   = 2'sb01;
    localparam logic signed [DIR_W-1:0] DIR_DOWN = 2'sb11;

endpackage

`default_nettype wire

[rtl/core/encoder_position_wrap_tracker.sv]
// Encoder position tracker: raw counter delta, scale, and modulo wrap into a range.
// Sequence: a primed sample in a non-inverted range passes through multiply, add, the one-bit-per-cycle
//   remainder loop, fix and finish steps; the finish step waits while the result register is full.
// All other transactions (first sample, inverted range, reset, set, unknown op) go straight to finish.
// Throughput: one transaction at a time; a new item is taken once the result is registered.
// Reset: rst_n is asynchronous, active low; it loads register defaults, clears the primed
//   flag and last raw count, and sets the position to the initial_count default.
`default_nettype none

module encoder_position_wrap_tracker
    import ewt_pkg::*;
#(
    parameter int unsigned COUNTER_BITS = 16
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,

    // Configuration write port
    input  wire logic                    cfg_we,
    input  wire logic [CFGI_W-1:0]       cfg_index,
    input  wire logic [CFG_W-1:0]        cfg_data,

    // Input item channel
    input  wire logic                    item_valid,
    output logic                         item_stall,
    input  wire logic [OP_W-1:0]         op,
    input  wire logic [POS_W-1:0]        raw_count,
    input  wire logic [POS_W-1:0]        set_value,

    // Result channel
    output logic                         result_valid,
    input  wire logic                    result_stall,
    output logic [POS_W-1:0]             position,
    output logic signed [DIR_W-1:0]      direction
);

    // Raw counter bits that take part in the difference.
    localparam int unsigned RAW_W  = (COUNTER_BITS < POS_W) ? COUNTER_BITS : POS_W;
    // Scaled difference: counter-wide signed times 9-bit positive sensitivity.
    localparam int unsigned PROD_W = COUNTER_BITS + SENS_W + 1;
    // Offset from min_count: scaled difference plus a 17-bit signed position offset.
    localparam int unsigned SUM_W  = ((COUNTER_BITS > SPAN_W) ? COUNTER_BITS : SPAN_W)
                                     + SENS_W + 1;
    localparam int unsigned CNT_W  = $clog2(SUM_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SUM_W - 1);

    // Sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_ADD  = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_FIX  = 3'd4;
    localparam logic [2:0] S_FIN  = 3'd5;

    // Control state
    logic [2:0]              state_reg,     state_next;
    logic                    primed_reg,    primed_next;
    logic [RAW_W-1:0]        last_raw_reg,  last_raw_next;
    pos_t                    pos_reg,       pos_next;
    logic                    result_valid_reg, result_valid_next;
    logic [CNT_W-1:0]        cnt_reg,       cnt_next;

    // Configuration registers
    pos_t                    min_reg;
    pos_t                    max_reg;
    logic [SENS_W-1:0]       sens_reg;
    pos_t                    initial_reg;

    // Datapath registers
    logic signed [COUNTER_BITS-1:0] diff_reg,      diff_next;
    logic signed [PROD_W-1:0]       prod_reg,      prod_next;
    logic [SUM_W-1:0]               dividend_reg,  dividend_next;
    logic                           neg_reg,       neg_next;
    span_t                          rem_reg,       rem_next;
    pos_t                           pos_calc_reg,  pos_calc_next;
    pos_t                           position_reg,  position_next;
    logic signed [DIR_W-1:0]        direction_reg, direction_next;

    // Combinational helpers
    logic                           inverted;
    span_t                          span;
    logic                           out_free;
    logic [COUNTER_BITS-1:0]        raw_ext;
    logic [COUNTER_BITS-1:0]        last_ext;
    logic signed [SENS_W:0]         sens_ext;
    logic [SUM_W-1:0]               offset;
    logic [SPAN_W:0]                trial;
    logic                           trial_ge;
    span_t                          wrapped;
    pos_t                           clamped;
    pos_t                           final_pos;

    assign inverted = max_reg < min_reg;
    // Range size; only used when the range is not inverted, so it is 1..65536.
    assign span     = SPAN_W'({1'b0, max_reg}) - SPAN_W'({1'b0, min_reg}) + SPAN_W'(1);
    // The result register can take a new value when empty or being drained.
    assign out_free = !result_valid_reg || !result_stall;

    assign raw_ext  = COUNTER_BITS'(raw_count[RAW_W-1:0]);
    assign last_ext = COUNTER_BITS'(last_raw_reg);
    assign sens_ext = signed'({1'b0, sens_reg});

    // Signed offset of the new sum from min_count.
    assign offset = SUM_W'(prod_reg) + SUM_W'({1'b0, pos_reg}) - SUM_W'({1'b0, min_reg});

    // Restoring step: shift in one dividend bit, subtract the span when it fits.
    assign trial    = {rem_reg, dividend_reg[SUM_W-1]};
    assign trial_ge = trial >= (SPAN_W+1)'(span);

    // Fold a negative offset back into [0, span).
    assign wrapped  = (neg_reg && (rem_reg != '0)) ? span - rem_reg : rem_reg;

    // Clamp the set value: floor to min first, then cap at max.
    always_comb
    begin
        clamped = set_value;
        if (clamped < min_reg)
        begin
            clamped = min_reg;
        end
        if (clamped > max_reg)
        begin
            clamped = max_reg;
        end
    end

    // An inverted range pins the position to min_count after every item.
    assign final_pos = inverted ? min_reg : pos_calc_reg;

    // Sequencer and datapath next-state logic
    always_comb
    begin
        state_next        = state_reg;
        primed_next       = primed_reg;
        last_raw_next     = last_raw_reg;
        pos_next          = pos_reg;
        result_valid_next = result_valid_reg && result_stall;
        cnt_next          = cnt_reg;
        diff_next         = diff_reg;
        prod_next         = prod_reg;
        dividend_next     = dividend_reg;
        neg_next          = neg_reg;
        rem_next          = rem_reg;
        pos_calc_next     = pos_calc_reg;
        position_next     = position_reg;
        direction_next    = direction_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    state_next    = S_FIN;
                    pos_calc_next = pos_reg;
                    unique case (op)
                        OP_SAMPLE:
                        begin
                            last_raw_next = raw_count[RAW_W-1:0];
                            if (!primed_reg)
                            begin
                                // First sample only latches the counter.
                                primed_next = 1'b1;
                            end
                            else if (!inverted)
                            begin
                                diff_next  = signed'(raw_ext - last_ext);
                                state_next = S_MUL;
                            end
                        end
                        OP_RESET:
                        begin
                            // Initial value is loaded as is, even outside the range.
                            pos_calc_next = initial_reg;
                        end
                        OP_SET:
                        begin
                            pos_calc_next = clamped;
                        end
                        default:
                        begin
                            // Unknown op: hold the position.
                            pos_calc_next = pos_reg;
                        end
                    endcase
                end
            end
            S_MUL:
            begin
                prod_next  = diff_reg * sens_ext;
                state_next = S_ADD;
            end
            S_ADD:
            begin
                neg_next      = offset[SUM_W-1];
                dividend_next = offset[SUM_W-1] ? (~offset + SUM_W'(1)) : offset;
                rem_next      = '0;
                cnt_next      = '0;
                state_next    = S_DIV;
            end
            S_DIV:
            begin
                rem_next      = trial_ge ? SPAN_W'(trial - (SPAN_W+1)'(span))
                                         : trial[SPAN_W-1:0];
                dividend_next = {dividend_reg[SUM_W-2:0], 1'b0};
                cnt_next      = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_LAST)
                begin
                    state_next = S_FIX;
                end
            end
            S_FIX:
            begin
                pos_calc_next = POS_W'(SPAN_W'({1'b0, min_reg}) + wrapped);
                state_next    = S_FIN;
            end
            S_FIN:
            begin
                // Hold here until the result register is free.
                if (out_free)
                begin
                    pos_next          = final_pos;
                    position_next     = final_pos;
                    result_valid_next = 1'b1;
                    if (final_pos > pos_reg)
                    begin
                        direction_next = DIR_UP;
                    end
                    else if (final_pos < pos_reg)
                    begin
                        direction_next = DIR_DOWN;
                    end
                    else
                    begin
                        direction_next = DIR_ZERO;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            primed_reg       <= 1'b0;
            last_raw_reg     <= '0;
            pos_reg          <= INITIAL_RESET;
            result_valid_reg <= 1'b0;
            cnt_reg          <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            primed_reg       <= primed_next;
            last_raw_reg     <= last_raw_next;
            pos_reg          <= pos_next;
            result_valid_reg <= result_valid_next;
            cnt_reg          <= cnt_next;
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg     <= MIN_RESET;
            max_reg     <= MAX_RESET;
            sens_reg    <= SENS_RESET;
            initial_reg <= INITIAL_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MIN:     min_reg     <= cfg_data;
                REG_MAX:     max_reg     <= cfg_data;
                REG_SENS:    sens_reg    <= cfg_data[SENS_W-1:0];
                REG_INITIAL: initial_reg <= cfg_data;
                default:     ;
            endcase
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        diff_reg      <= diff_next;
        prod_reg      <= prod_next;
        dividend_reg  <= dividend_next;
        neg_reg       <= neg_next;
        rem_reg       <= rem_next;
        pos_calc_reg  <= pos_calc_next;
        position_reg  <= position_next;
        direction_reg <= direction_next;
    end

    assign item_stall   = state_reg != S_IDLE;
    assign result_valid = result_valid_reg;
    assign position     = position_reg;
    assign direction    = direction_reg;

    // An accepted item always enters the multiply step or the finish step.
    a_accept_path: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && !item_stall) |=> (state_reg == S_MUL || state_reg == S_FIN))
        else $error("accepted item took an unexpected path");

    // A new result only appears out of the finish step.
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_next && !(result_valid_reg && result_stall)) |-> state_reg == S_FIN)
        else $error("result loaded outside the finish step");

    // The running remainder stays below the span.
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (rem_reg < span))
        else $error("remainder not below span");

    // A wrapped result lands inside the range.
    a_wrap_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIX) |=> (pos_calc_reg >= min_reg && pos_calc_reg <= max_reg))
        else $error("wrapped position outside range");

    // With an inverted range the reported position is min_count.
    a_inverted_min: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN && out_free && inverted) |=> (position_reg == $past(min_reg)))
        else $error("inverted range did not pin position to min");

endmodule

`default_nettype wire
